// ----- rtl/bsrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_pkg
// Shared widths, constants, codes and controller/datapath interface types
// for the blower speed ramp controller.
// ----------------------------------------------------------------------------
package bsrc_pkg;

    // field widths
    localparam int SPEED_W    = 16;
    localparam int TIME_W     = 32;
    localparam int FLOW_W     = 19;
    localparam int PRESS_W    = 10;
    localparam int OPCODE_W   = 2;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // register reset values
    localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd300;
    localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd1800;

    // pressure ceiling, also the full-speed base term
    localparam logic [PRESS_W-1:0] PRESS_MAX = 10'd703;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 64;

    // reciprocal constants: floor(x / d) == (x * RECIP) >> SH over the value range
    localparam logic [MUL_W-1:0] RECIP_1000   = 32'd274877907;
    localparam int               RECIP_1000_SH = 38;
    localparam logic [MUL_W-1:0] RECIP_100    = 32'd671089;
    localparam int               RECIP_100_SH  = 26;
    localparam logic [MUL_W-1:0] RECIP_100000 = 32'd175921861;
    localparam int               RECIP_100000_SH = 44;
    // 832 / 1000000 reduced to 104 / 125000
    localparam logic [MUL_W-1:0] RECIP_125000 = 32'd1125899907;
    localparam int               RECIP_125000_SH = 47;
    localparam logic [MUL_W-1:0] FLOW_LIN     = 32'd281;
    localparam logic [MUL_W-1:0] FLOW_QUAD    = 32'd104;

    // intermediate widths
    localparam int INC_W      = 23;  // elapsed / 1000
    localparam int Q_W        = 12;  // |flow| / 100
    localparam int LIN_W      = 27;  // 281 * |flow|
    localparam int T1_W       = 10;  // linear flow term
    localparam int QSQ_W      = 23;  // q * q
    localparam int QUAD_W     = 30;  // 104 * q * q
    localparam int T2_W       = 13;  // quadratic flow term
    localparam int FT_W       = 14;  // signed flow term
    localparam int DIVIDEND_W = 26;  // 703 * speed
    localparam int RES_W      = 28;  // signed pressure before clamp

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET   = 2'd0,
        OP_TICK  = 2'd1,
        OP_STOP  = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic {
        REG_MIN_SPEED = 1'b0,
        REG_MAX_SPEED = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_TICK,
        MUL_FLOW_Q,
        MUL_FLOW_LIN,
        MUL_T1_RECIP,
        MUL_Q_SQ,
        MUL_Q_QUAD,
        MUL_T2_RECIP,
        MUL_SPEED
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_MUL,
        ST_Q_ABS,
        ST_Q_LIN,
        ST_Q_T1,
        ST_Q_SQ,
        ST_Q_QUAD,
        ST_Q_T2,
        ST_Q_SPEED,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic    load_in;
        t_mul_op mul_op;
        logic    cap_q;
        logic    cap_t1;
        logic    cap_t2;
        logic    div_start;
        logic    commit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_skip;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/blower_speed_ramp_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blower_speed_ramp_controller
// Blower speed control with ramp-up limit and pressure estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on the s_axis channel carry an opcode in tuser (set target,
//   ramp tick, stop, pressure query) with target, timestamp and flow in
//   tdata. Each beat yields one result beat on m_axis with the applied
//   speed, target, status flags and the pressure estimate.
//   min_speed and max_speed are written over the APB port; write them only
//   while no beat is in flight.
// Sequence from accept to result valid:
//   set target and stop go straight to commit; ramp tick takes one multiplier
//   step first; pressure query runs its multiplier steps and then the divide,
//   which is skipped when the speed term needs no divide. The speed term is
//   divided one bit per cycle; the constant divisions run through one shared
//   32x32 multiplier, one step per cycle. One beat is worked at a time; the
//   next is accepted the cycle after the result is registered.
// Reset: speed and target clear, blower halted, registers to 300 and 1800.
// Stall: a result waits in the output register while m_axis_tready is low;
//   a later beat may be accepted and worked but commits only once the
//   output register is free.
// ----------------------------------------------------------------------------
module blower_speed_ramp_controller
    import bsrc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input beats
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: target_speed[15:0], timestamp_us[47:16], flow[66:48], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [OPCODE_W-1:0]    s_axis_tuser,
    // result beats
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: speed[15:0], target[31:16], is_stopped[32], drive_update[33],
    //        out_of_range[34], pressure[44:35], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [SPEED_W-1:0] r_min_speed;
    logic [SPEED_W-1:0] r_max_speed;
    logic               w_cfg_wr;
    t_reg_idx           w_reg_idx;
    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;

    // register file
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_speed <= MIN_SPEED_RST;
            r_max_speed <= MAX_SPEED_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_MIN_SPEED: r_min_speed <= pwdata[SPEED_W-1:0];
                REG_MAX_SPEED: r_max_speed <= pwdata[SPEED_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_MIN_SPEED: prdata = {{(APB_DATA_W-SPEED_W){1'b0}}, r_min_speed};
            REG_MAX_SPEED: prdata = {{(APB_DATA_W-SPEED_W){1'b0}}, r_max_speed};
        endcase
    end

    // sequencer
    bsrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (t_opcode'(s_axis_tuser)),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // datapath
    bsrc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_opcode (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_min_speed (r_min_speed),
        .i_max_speed (r_max_speed),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ----- rtl/bsrc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsrc_div
    import bsrc_pkg::*;
#(
    parameter int DIVIDEND_BITS = DIVIDEND_W,
    parameter int DIVISOR_BITS  = SPEED_W
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic                     o_done,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [CNT_W-1:0]         r_cnt;
    logic [DIVISOR_BITS-1:0]  r_rem;
    logic [DIVIDEND_BITS-1:0] r_quo;
    logic [DIVISOR_BITS-1:0]  r_divisor;

    logic [DIVISOR_BITS:0]    w_trial;
    logic [DIVISOR_BITS:0]    w_diff;
    logic                     w_ge;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_quo[DIVIDEND_BITS-1]};
    assign w_diff  = w_trial - {1'b0, r_divisor};
    assign w_ge    = ~w_diff[DIVISOR_BITS];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DIVISOR_BITS-1:0] : w_trial[DIVISOR_BITS-1:0];
            r_quo <= {r_quo[DIVIDEND_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    // no restart while a division runs
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // last step ends the run with a done pulse
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == CNT_W'(1)) |=> (r_done && !r_busy))
        else $error("divider did not finish after last step");

endmodule

// ----- rtl/bsrc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_ctrl
// Sequencer: accepts a beat, walks the datapath through the steps of its
// opcode, and commits once the output register is free.
// ----------------------------------------------------------------------------
module bsrc_ctrl
    import bsrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_opcode  i_opcode,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_opcode)
                        OP_TICK:        n_state = ST_TICK_MUL;
                        OP_QUERY:       n_state = ST_Q_ABS;
                        OP_SET, OP_STOP: n_state = ST_COMMIT;
                    endcase
                end
            end
            ST_TICK_MUL:  n_state = ST_COMMIT;
            ST_Q_ABS:     n_state = ST_Q_LIN;
            ST_Q_LIN:     n_state = ST_Q_T1;
            ST_Q_T1:      n_state = ST_Q_SQ;
            ST_Q_SQ:      n_state = ST_Q_QUAD;
            ST_Q_QUAD:    n_state = ST_Q_T2;
            ST_Q_T2:      n_state = ST_Q_SPEED;
            ST_Q_SPEED:   n_state = ST_DIV_START;
            ST_DIV_START: n_state = i_stat.div_skip ? ST_COMMIT : ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_stat.div_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.mul_op = MUL_NONE;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_TICK_MUL:  o_cmd.mul_op = MUL_TICK;
            ST_Q_ABS:     o_cmd.mul_op = MUL_FLOW_Q;
            ST_Q_LIN: begin
                o_cmd.mul_op = MUL_FLOW_LIN;
                o_cmd.cap_q  = 1'b1;
            end
            ST_Q_T1:      o_cmd.mul_op = MUL_T1_RECIP;
            ST_Q_SQ: begin
                o_cmd.mul_op = MUL_Q_SQ;
                o_cmd.cap_t1 = 1'b1;
            end
            ST_Q_QUAD:    o_cmd.mul_op = MUL_Q_QUAD;
            ST_Q_T2:      o_cmd.mul_op = MUL_T2_RECIP;
            ST_Q_SPEED: begin
                o_cmd.mul_op = MUL_SPEED;
                o_cmd.cap_t2 = 1'b1;
            end
            ST_DIV_START: o_cmd.div_start = ~i_stat.div_skip;
            ST_DIV_WAIT:  o_cmd.div_start = 1'b0;
            ST_COMMIT:    o_cmd.commit = i_stat.out_free;
            default:      o_cmd.commit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/bsrc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsrc_dp
// Datapath: input beat registers, blower state, shared multiplier, pressure
// divider and the output register.
// ----------------------------------------------------------------------------
module bsrc_dp
    import bsrc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    input  logic [OPCODE_W-1:0]    i_in_opcode,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic [SPEED_W-1:0]     i_min_speed,
    input  logic [SPEED_W-1:0]     i_max_speed,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data
);

    // input beat
    t_opcode                r_opcode;
    logic [SPEED_W-1:0]     r_target_in;
    logic [TIME_W-1:0]      r_ts;
    logic [FLOW_W-1:0]      r_flow;

    // blower state
    logic [SPEED_W-1:0]     r_applied;
    logic [SPEED_W-1:0]     r_goal;
    logic                   r_halted;
    logic [TIME_W-1:0]      r_last_time;
    logic [SPEED_W-1:0]     n_applied;
    logic [SPEED_W-1:0]     n_goal;
    logic                   n_halted;
    logic [TIME_W-1:0]      n_last_time;

    // work registers
    logic [PROD_W-1:0]      r_prod;
    logic [Q_W-1:0]         r_q;
    logic [T1_W-1:0]        r_t1;
    logic [T2_W-1:0]        r_t2;

    // output register
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [MUL_W-1:0]       w_mul_a;
    logic [MUL_W-1:0]       w_mul_b;
    logic [PROD_W-1:0]      w_prod;
    logic                   w_flow_neg;
    logic [FLOW_W-1:0]      w_flow_mag;
    logic [TIME_W-1:0]      w_elapsed;
    logic [INC_W-1:0]       w_inc;
    logic [INC_W:0]         w_up;
    logic [SPEED_W-1:0]     w_run;
    logic                   w_run_ok;
    logic                   w_tgt_ok;
    logic                   w_div_skip;
    logic                   w_div_done;
    logic [DIVIDEND_W-1:0]  w_quotient;
    logic [DIVIDEND_W-1:0]  w_base;
    logic signed [FT_W-1:0] w_ft;
    logic [RES_W-1:0]       w_res;
    logic [PRESS_W-1:0]     w_press;
    logic                   w_upd;
    logic                   w_oor;
    logic [PRESS_W-1:0]     w_press_out;

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_opcode    <= t_opcode'(i_in_opcode);
            r_target_in <= i_in_data[SPEED_W-1:0];
            r_ts        <= i_in_data[SPEED_W +: TIME_W];
            r_flow      <= i_in_data[SPEED_W+TIME_W +: FLOW_W];
        end
    end

    // flow magnitude and sign
    assign w_flow_neg = r_flow[FLOW_W-1];
    assign w_flow_mag = w_flow_neg ? (~r_flow + 1'b1) : r_flow;
    assign w_elapsed  = r_ts - r_last_time;

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_op)
            MUL_TICK: begin
                w_mul_a = w_elapsed;
                w_mul_b = RECIP_1000;
            end
            MUL_FLOW_Q: begin
                w_mul_a = MUL_W'(w_flow_mag);
                w_mul_b = RECIP_100;
            end
            MUL_FLOW_LIN: begin
                w_mul_a = MUL_W'(w_flow_mag);
                w_mul_b = FLOW_LIN;
            end
            MUL_T1_RECIP: begin
                w_mul_a = MUL_W'(r_prod[LIN_W-1:0]);
                w_mul_b = RECIP_100000;
            end
            MUL_Q_SQ: begin
                w_mul_a = MUL_W'(r_q);
                w_mul_b = MUL_W'(r_q);
            end
            MUL_Q_QUAD: begin
                w_mul_a = MUL_W'(r_prod[QSQ_W-1:0]);
                w_mul_b = FLOW_QUAD;
            end
            MUL_T2_RECIP: begin
                w_mul_a = MUL_W'(r_prod[QUAD_W-1:0]);
                w_mul_b = RECIP_125000;
            end
            MUL_SPEED: begin
                w_mul_a = MUL_W'(r_applied);
                w_mul_b = MUL_W'(PRESS_MAX);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = {{(PROD_W-MUL_W){1'b0}}, w_mul_a} * {{(PROD_W-MUL_W){1'b0}}, w_mul_b};

    // product and partial terms
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_op != MUL_NONE) r_prod <= w_prod;
        if (i_cmd.cap_q)  r_q  <= r_prod[RECIP_100_SH +: Q_W];
        if (i_cmd.cap_t1) r_t1 <= r_prod[RECIP_100000_SH +: T1_W];
        if (i_cmd.cap_t2) r_t2 <= r_prod[RECIP_125000_SH +: T2_W];
    end

    // speed term divider: 703 * speed / max_speed
    assign w_div_skip = (r_applied == i_max_speed) || (i_max_speed == '0);

    bsrc_div #(
        .DIVIDEND_BITS (DIVIDEND_W),
        .DIVISOR_BITS  (SPEED_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod[DIVIDEND_W-1:0]),
        .i_divisor  (i_max_speed),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // pressure: base minus signed flow term, clamped
    assign w_base = w_div_skip ? DIVIDEND_W'(PRESS_MAX) : w_quotient;
    assign w_ft   = (w_flow_neg ? -$signed({{(FT_W-T1_W){1'b0}}, r_t1})
                                :  $signed({{(FT_W-T1_W){1'b0}}, r_t1}))
                  + $signed({{(FT_W-T2_W){1'b0}}, r_t2});
    assign w_res  = {{(RES_W-DIVIDEND_W){1'b0}}, w_base}
                  - {{(RES_W-FT_W){w_ft[FT_W-1]}}, w_ft};

    always_comb begin
        if (w_res[RES_W-1]) begin
            w_press = '0;
        end else if (w_res > RES_W'(PRESS_MAX)) begin
            w_press = PRESS_MAX;
        end else begin
            w_press = w_res[PRESS_W-1:0];
        end
    end

    // ramp step
    assign w_inc = r_prod[RECIP_1000_SH +: INC_W];
    assign w_up  = {{(INC_W+1-SPEED_W){1'b0}}, r_applied} + {1'b0, w_inc};

    always_comb begin
        if (r_goal > r_applied) begin
            w_run = (w_up < {{(INC_W+1-SPEED_W){1'b0}}, r_goal}) ? w_up[SPEED_W-1:0] : r_goal;
        end else begin
            w_run = r_goal;
        end
    end

    assign w_run_ok = (w_run >= i_min_speed) && (w_run <= i_max_speed);
    assign w_tgt_ok = (r_target_in >= i_min_speed) && (r_target_in <= i_max_speed);

    // state update on commit
    always_comb begin
        n_applied   = r_applied;
        n_goal      = r_goal;
        n_halted    = r_halted;
        n_last_time = r_last_time;
        w_upd       = 1'b0;
        w_oor       = 1'b0;
        w_press_out = '0;
        unique case (r_opcode)
            OP_SET: begin
                if (w_tgt_ok && (r_target_in != r_goal)) begin
                    n_last_time = r_ts;
                    n_goal      = r_target_in;
                    if (r_applied < i_min_speed) n_applied = i_min_speed;
                end
            end
            OP_TICK: begin
                n_last_time = r_ts;
                if (w_run_ok) begin
                    if (r_halted || (r_applied != w_run)) begin
                        n_applied = w_run;
                        n_halted  = 1'b0;
                        w_upd     = 1'b1;
                    end
                end else begin
                    w_oor = 1'b1;
                end
            end
            OP_STOP: begin
                n_applied = '0;
                n_goal    = '0;
                n_halted  = 1'b1;
                w_upd     = 1'b1;
            end
            OP_QUERY: begin
                w_press_out = w_press;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_applied   <= '0;
            r_goal      <= '0;
            r_halted    <= 1'b1;
            r_last_time <= '0;
        end else if (i_cmd.commit) begin
            r_applied   <= n_applied;
            r_goal      <= n_goal;
            r_halted    <= n_halted;
            r_last_time <= n_last_time;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {{(OUT_TDATA_W-2*SPEED_W-3-PRESS_W){1'b0}},
                           w_press_out, w_oor, w_upd, n_halted, n_goal, n_applied};
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out_data;
    assign o_stat.div_skip = w_div_skip;
    assign o_stat.div_done = w_div_done;
    assign o_stat.out_free = ~r_out_valid | i_out_ready;

    // a stop always leaves the blower halted at zero speed
    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_opcode == OP_STOP) |=> (r_halted && r_applied == '0 && r_goal == '0))
        else $error("stop did not halt the blower");

    // pressure estimate never leaves its clamp range
    a_press_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[2*SPEED_W+3 +: PRESS_W] <= PRESS_MAX))
        else $error("pressure above clamp");

endmodule

// ----- tb/blower_speed_ramp_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blower_speed_ramp_controller_tb
// Self-checking bench for the blower speed ramp controller.
// Drives set/tick/stop/query beats on the input stream and programs the speed
// limits over APB while the block is idle. A bit-accurate model of the speed
// ramp and the pressure estimate predicts every result beat, and the result
// stream is compared field by field against it. Both stream sides stall at
// random.
// ----------------------------------------------------------------------------
module blower_speed_ramp_controller_tb;
    import bsrc_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_WAIT      = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int PRINT_LIMIT   = 100;

    // pressure estimate constants
    localparam longint FLOW_Q_DIV     = 100;
    localparam longint FLOW_LIN_MUL   = 281;
    localparam longint FLOW_LIN_DIV   = 100000;
    localparam longint FLOW_QUAD_MUL  = 832;
    localparam longint FLOW_QUAD_DIV  = 1000000;
    localparam longint US_PER_STEP    = 1000;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0] target;
        logic               stopped;
        logic               drive_update;
        logic               out_of_range;
        logic [PRESS_W-1:0] pressure;
    } blower_result_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: target_speed[15:0], timestamp_us[47:16], flow[66:48], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser: opcode[1:0]
    logic [OPCODE_W-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: speed[15:0], target[31:16], is_stopped[32], drive_update[33],
    //        out_of_range[34], pressure[44:35], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // model state of the blower and its limits
    logic [SPEED_W-1:0] cur_speed = '0;
    logic [SPEED_W-1:0] cur_target = '0;
    logic               blower_halted = 1'b1;
    logic [TIME_W-1:0]  stamp_us = '0;
    logic [SPEED_W-1:0] lim_min = MIN_SPEED_RST;
    logic [SPEED_W-1:0] lim_max = MAX_SPEED_RST;

    blower_result_t pending_results[$];
    int  err_count = 0;
    int  cycle_count = 0;
    int  result_count = 0;
    bit  no_idle = 1'b0;

    blower_speed_ramp_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int draw_wait();
        return no_idle ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic logic speed_ok(logic [SPEED_W-1:0] v);
        return v >= lim_min && v <= lim_max;
    endfunction

    // quadratic pressure estimate, clamped to 0..PRESS_MAX
    function automatic logic [PRESS_W-1:0] pressure_estimate(logic signed [FLOW_W-1:0] flow);
        longint f, q, base, den, p;
        f = longint'(flow);
        q = f / FLOW_Q_DIV;
        den = longint'(lim_max);
        if (cur_speed == lim_max || lim_max == '0) begin
            base = longint'(PRESS_MAX);
        end else begin
            base = longint'(cur_speed);
            base = (base * longint'(PRESS_MAX)) / den;
        end
        p = base - (FLOW_LIN_MUL * f) / FLOW_LIN_DIV - (FLOW_QUAD_MUL * q * q) / FLOW_QUAD_DIV;
        if (p < 0) p = 0;
        if (p > longint'(PRESS_MAX)) p = longint'(PRESS_MAX);
        return p[PRESS_W-1:0];
    endfunction

    // advance the blower state by one beat and return the result it produces
    function automatic blower_result_t blower_next(t_opcode op, logic [SPEED_W-1:0] tgt,
                                                   logic [TIME_W-1:0] ts,
                                                   logic signed [FLOW_W-1:0] flow);
        blower_result_t r;
        logic [TIME_W-1:0]  elapsed;
        longint             ramp;
        logic [SPEED_W-1:0] run;
        r = '0;
        case (op)
            OP_SET: begin
                if (speed_ok(tgt) && tgt != cur_target) begin
                    stamp_us = ts;
                    cur_target = tgt;
                    if (cur_speed < lim_min) cur_speed = lim_min;
                end
            end
            OP_TICK: begin
                // ramp up by elapsed ms, computed wide, capped at the target
                if (cur_target > cur_speed) begin
                    elapsed = ts - stamp_us;
                    ramp = longint'(cur_speed);
                    ramp = ramp + longint'(elapsed) / US_PER_STEP;
                    run = (ramp < longint'(cur_target)) ? ramp[SPEED_W-1:0] : cur_target;
                end else begin
                    run = cur_target;
                end
                stamp_us = ts;
                if (speed_ok(run)) begin
                    if (blower_halted || cur_speed != run) begin
                        cur_speed = run;
                        blower_halted = 1'b0;
                        r.drive_update = 1'b1;
                    end
                end else begin
                    r.out_of_range = 1'b1;
                end
            end
            OP_STOP: begin
                cur_speed = '0;
                cur_target = '0;
                blower_halted = 1'b1;
                r.drive_update = 1'b1;
            end
            default: r.pressure = pressure_estimate(flow);
        endcase
        r.speed = cur_speed;
        r.target = cur_target;
        r.stopped = blower_halted;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint expv, longint gotv);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] mismatch %s at result %0d: expected %0d got %0d",
                     $realtime, what, result_count, expv, gotv);
    endtask

    // result checking and prediction on every accepted beat
    always @(posedge i_clk) begin : result_monitor
        blower_result_t want, got;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.speed        = m_axis_tdata[15:0];
                got.target       = m_axis_tdata[31:16];
                got.stopped      = m_axis_tdata[32];
                got.drive_update = m_axis_tdata[33];
                got.out_of_range = m_axis_tdata[34];
                got.pressure     = m_axis_tdata[44:35];
                if (pending_results.size() == 0) begin
                    report_mismatch("result beat with nothing pending", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    if (got.speed !== want.speed)
                        report_mismatch("speed", want.speed, got.speed);
                    if (got.target !== want.target)
                        report_mismatch("target", want.target, got.target);
                    if (got.stopped !== want.stopped)
                        report_mismatch("is_stopped", want.stopped, got.stopped);
                    if (got.drive_update !== want.drive_update)
                        report_mismatch("drive_update", want.drive_update, got.drive_update);
                    if (got.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", want.out_of_range, got.out_of_range);
                    if (got.pressure !== want.pressure)
                        report_mismatch("pressure", want.pressure, got.pressure);
                end
                result_count++;
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(blower_next(t_opcode'(s_axis_tuser),
                                                      s_axis_tdata[15:0],
                                                      s_axis_tdata[47:16],
                                                      s_axis_tdata[66:48]));
        end
    end

    // result side: random stall before each beat
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // one input beat; valid stays high when the next beat follows without a gap
    task automatic send_beat(t_opcode op, logic [SPEED_W-1:0] tgt, logic [TIME_W-1:0] ts,
                             logic signed [FLOW_W-1:0] flow);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, flow, ts, tgt};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop sending and wait until every pending result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(bit wr, t_reg_idx idx, logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'(int'(idx) * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_limit_reg(t_reg_idx idx, logic [SPEED_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== APB_DATA_W'(want))
            report_mismatch(idx == REG_MIN_SPEED ? "min_speed readback" : "max_speed readback",
                            want, rd);
    endtask

    // program both limits while idle; upper data bits are noise
    task automatic program_limits(logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] hi);
        logic [APB_DATA_W-1:0] rd;
        drain();
        apb_access(1'b1, REG_MIN_SPEED, {16'($urandom), lo}, rd);
        apb_access(1'b1, REG_MAX_SPEED, {16'($urandom), hi}, rd);
        lim_min = lo;
        lim_max = hi;
        check_limit_reg(REG_MIN_SPEED, lo);
        check_limit_reg(REG_MAX_SPEED, hi);
    endtask

    task automatic test_register_access();
        check_limit_reg(REG_MIN_SPEED, MIN_SPEED_RST);
        check_limit_reg(REG_MAX_SPEED, MAX_SPEED_RST);
        program_limits(16'hA5A5, 16'h5A5A);
        program_limits(16'hFFFF, 16'h0000);
        program_limits(MIN_SPEED_RST, MAX_SPEED_RST);
    endtask

    // ramp, bounds, wrap and pressure corners under reset limits
    task automatic test_directed_ramp();
        send_beat(OP_QUERY, '0, '0, '0);
        send_beat(OP_TICK, '0, 32'd1000, '0);            // tick with no target
        send_beat(OP_SET, 16'hFFFF, 32'd2000, '0);       // targets outside bounds
        send_beat(OP_SET, 16'd0, 32'd2000, '0);
        send_beat(OP_SET, 16'd299, 32'd2000, '0);
        send_beat(OP_SET, 16'd300, 32'd10000, '0);
        send_beat(OP_SET, 16'd300, 32'd11000, '0);       // unchanged target
        send_beat(OP_TICK, '0, 32'd10500, '0);
        send_beat(OP_SET, 16'd1800, 32'd20000, '0);
        send_beat(OP_TICK, '0, 32'd520000, '0);
        send_beat(OP_TICK, '0, 32'hFFFF_FF00, '0);       // saturates at target
        send_beat(OP_QUERY, '0, '0, 19'sd0);
        send_beat(OP_QUERY, '0, '0, 19'sd160000);
        send_beat(OP_QUERY, '0, '0, -19'sd160000);
        send_beat(OP_QUERY, '0, '0, 19'sd20000);
        send_beat(OP_QUERY, '0, '0, -19'sd20000);
        send_beat(OP_SET, 16'd1000, 32'hFFFF_FFFF, '0);  // lower target
        send_beat(OP_TICK, '0, 32'd999, '0);
        send_beat(OP_SET, 16'd1700, 32'hFFFF_FC18, '0);
        send_beat(OP_TICK, '0, 32'h0007_A120, '0);       // elapsed across the wrap
        send_beat(OP_QUERY, '0, '0, 19'sh3FFFF);
        send_beat(OP_QUERY, '0, '0, 19'sh40000);
        send_beat(OP_QUERY, '0, '0, 19'sd1);
        send_beat(OP_STOP, 16'hFFFF, 32'hFFFF_FFFF, 19'sh7FFFF);
        send_beat(OP_QUERY, '0, '0, -19'sd5000);
        send_beat(OP_TICK, '0, 32'd600000, '0);
    endtask

    // zero and full-scale limits, zero max_speed, crossed limits
    task automatic test_limit_corners();
        program_limits(16'd0, 16'hFFFF);
        send_beat(OP_TICK, '0, 32'd50, '0);              // zero speed accepted
        send_beat(OP_SET, 16'd65000, 32'd100, '0);
        send_beat(OP_TICK, '0, 32'd70_000_100, '0);
        send_beat(OP_SET, 16'hFFFF, 32'd200, '0);
        send_beat(OP_TICK, '0, 32'd199, '0);             // wide ramp sum
        send_beat(OP_QUERY, '0, '0, 19'sd0);
        send_beat(OP_QUERY, '0, '0, -19'sd1);
        send_beat(OP_SET, 16'd500, 32'd300, '0);
        send_beat(OP_TICK, '0, 32'd400, '0);
        program_limits(16'd0, 16'd0);
        send_beat(OP_QUERY, '0, '0, 19'sd1000);          // zero max, speed differs
        send_beat(OP_TICK, '0, 32'd500, '0);
        send_beat(OP_SET, 16'd0, 32'd600, '0);
        send_beat(OP_TICK, '0, 32'd700, '0);
        send_beat(OP_QUERY, '0, '0, 19'sd1000);
        program_limits(16'd1000, 16'd500);
        send_beat(OP_SET, 16'd700, 32'd800, '0);
        send_beat(OP_SET, 16'd1000, 32'd800, '0);
        send_beat(OP_TICK, '0, 32'd900, '0);
        send_beat(OP_QUERY, '0, '0, 19'sd0);
        send_beat(OP_STOP, '0, '0, '0);
    endtask

    // mostly plausible control traffic with random content, some noise
    task automatic test_random_traffic();
        logic [SPEED_W-1:0]       lo, hi, last_target, tgt;
        logic [TIME_W-1:0]        now_us;
        logic signed [FLOW_W-1:0] flow;
        t_opcode                  op;
        int                       r;
        now_us = $urandom;
        last_target = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin lo = MIN_SPEED_RST; hi = MAX_SPEED_RST; end
                1: begin lo = '0; hi = 16'hFFFF; end
                2: begin
                    lo = SPEED_W'($urandom_range(0, 3000));
                    hi = lo + SPEED_W'($urandom_range(1, 4000));
                end
                3: begin lo = SPEED_W'($urandom); hi = SPEED_W'($urandom); end
                4: begin lo = SPEED_W'($urandom_range(100, 5000)); hi = lo; end
                default: begin
                    lo = SPEED_W'($urandom_range(0, 500));
                    hi = lo + SPEED_W'($urandom_range(1, 300));
                end
            endcase
            program_limits(lo, hi);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (i == PHASE_ITEMS / 2) drain();
                // time moves on mostly in small steps, sometimes jumps
                r = $urandom_range(0, 99);
                if (r < 70) now_us += $urandom_range(0, 400000);
                else if (r < 92) now_us += $urandom_range(0, 30_000_000);
                else now_us = $urandom;
                r = $urandom_range(0, 99);
                if (r < 10) tgt = last_target;
                else if (r < 85) tgt = SPEED_W'($urandom_range(lim_min, lim_max));
                else tgt = SPEED_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 65) flow = FLOW_W'(int'($urandom_range(0, 320000)) - 160000);
                else if (r < 85) flow = FLOW_W'(int'($urandom_range(0, 6000)) - 3000);
                else flow = FLOW_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    op = OP_SET;
                    last_target = tgt;
                end else if (r < 65) begin
                    op = OP_TICK;
                end else if (r < 70) begin
                    op = OP_STOP;
                end else begin
                    op = OP_QUERY;
                end
                send_beat(op, tgt, now_us, flow);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_access();
        test_directed_ramp();
        test_limit_corners();
        test_random_traffic();
        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
